// ----- hdl/plm_pkg.sv -----
package plm_pkg;

	localparam logic [63:0] MAX64 = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam logic [47:0] MAX48 = 48'hFFFF_FFFF_FFFF;
	localparam logic [31:0] MAX32 = 32'hFFFF_FFFF;

	typedef struct packed {
		logic [31:0] count;
		logic [31:0] mean;
		logic [15:0] min_v;
		logic [15:0] max_v;
		logic [47:0] isum;
		logic [47:0] xsum;
		logic [47:0] ysum;
		logic [63:0] m2;
		logic [63:0] m3;
		logic [63:0] m4;
		logic [63:0] var_v;
	} rec_t;

	typedef struct packed {
		logic start;
		logic is_div;
		logic sh16;
	} ar_req_t;

	typedef struct packed {
		logic        neg;
		logic [63:0] mag;
	} sv_t;

endpackage

// ----- hdl/plm_ram.sv -----
module plm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- hdl/plm_arith.sv -----
module plm_arith (
	input  logic              clk,
	input  logic              arst_n,
	input  plm_pkg::ar_req_t  req,
	input  logic [63:0]       a,
	input  logic [63:0]       b,
	output logic              done,
	output logic [63:0]       result
);

	import plm_pkg::*;

	localparam logic [1:0] A_IDLE = 2'd0;
	localparam logic [1:0] A_MUL  = 2'd1;
	localparam logic [1:0] A_DIV  = 2'd2;

	logic [1:0]   state_q;
	logic [5:0]   cnt_q;
	logic         done_q;
	logic [63:0]  a_q;
	logic [63:0]  b_q;
	logic         sh16_q;
	logic [63:0]  p_q;
	logic [1:0]   pidx_q;
	logic [127:0] acc_q;
	logic [63:0]  num_q;
	logic [32:0]  rem_q;
	logic [63:0]  res_q;

	logic [31:0]  a_half;
	logic [31:0]  b_half;
	logic [63:0]  p_nxt;
	logic [127:0] p_ext;
	logic [127:0] acc_nxt;
	logic [63:0]  mul_sat;
	logic [33:0]  trial;
	logic [33:0]  diff;
	logic         ge;
	logic [32:0]  rem_nxt;

	always_comb begin
		a_half = cnt_q[0] ? a_q[63:32] : a_q[31:0];
		b_half = cnt_q[1] ? b_q[63:32] : b_q[31:0];
		p_nxt = {32'b0, a_half} * {32'b0, b_half};
		case (pidx_q)
			2'd0: p_ext = {64'b0, p_q};
			2'd3: p_ext = {p_q, 64'b0};
			default: p_ext = {32'b0, p_q, 32'b0};
		endcase
		acc_nxt = acc_q + p_ext;
		if (sh16_q) begin
			mul_sat = (acc_nxt[127:80] != '0) ? MAX64 : acc_nxt[79:16];
		end else begin
			mul_sat = (acc_nxt[127:64] != '0) ? MAX64 : acc_nxt[63:0];
		end
		trial = {rem_q, num_q[63]};
		diff = trial - {1'b0, b_q[32:0]};
		ge = trial >= {1'b0, b_q[32:0]};
		rem_nxt = ge ? diff[32:0] : trial[32:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= A_IDLE;
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				A_IDLE: begin
					cnt_q <= '0;
					if (req.start) begin
						state_q <= req.is_div ? A_DIV : A_MUL;
					end
				end
				A_MUL: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd4) begin
						done_q <= 1'b1;
						state_q <= A_IDLE;
					end
				end
				A_DIV: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd63) begin
						done_q <= 1'b1;
						state_q <= A_IDLE;
					end
				end
				default: begin
					state_q <= A_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			A_IDLE: begin
				if (req.start) begin
					a_q <= a;
					b_q <= b;
					sh16_q <= req.sh16;
					acc_q <= '0;
					num_q <= a;
					rem_q <= '0;
				end
			end
			A_MUL: begin
				p_q <= p_nxt;
				pidx_q <= cnt_q[1:0];
				if (cnt_q != 6'd0) begin
					acc_q <= acc_nxt;
				end
				if (cnt_q == 6'd4) begin
					res_q <= mul_sat;
				end
			end
			A_DIV: begin
				num_q <= {num_q[62:0], ge};
				rem_q <= rem_nxt;
				if (cnt_q == 6'd63) begin
					res_q <= {num_q[62:0], ge};
				end
			end
			default: begin
			end
		endcase
	end

	assign done = done_q;
	assign result = res_q;

endmodule

// ----- hdl/per_label_moment_accumulator_core.sv -----
// channel | signals                                   | direction
// input   | in_valid, in_ready, label_id, pixel_*     | in
// output  | out_valid, out_ready, statistics fields   | out
//
// a background or out-of-table pixel is taken and gives no result
// a first pixel of a label is written without arithmetic; a later one is paced
// by the bit-serial divider (three divisions) and fifteen
// multiplies of four 32x32 partial products in the shared arithmetic unit
// arst_n clears the label seen bits and all control state at once
// a finished result waits in the output register while the next pixel is taken
module per_label_moment_accumulator_core #(
	parameter int LABEL_COUNT    = 256,
	parameter int INTENSITY_BITS = 16,
	parameter int COORD_BITS     = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         label_id,
	input  logic [15:0]        pixel_intensity,
	input  logic [15:0]        pixel_x,
	input  logic [15:0]        pixel_y,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [31:0]        pixel_count,
	output logic [31:0]        mean_value,
	output logic [15:0]        min_value,
	output logic [15:0]        max_value,
	output logic [47:0]        intensity_sum,
	output logic [47:0]        x_sum,
	output logic [47:0]        y_sum,
	output logic [63:0]        second_moment,
	output logic signed [63:0] third_moment,
	output logic [63:0]        fourth_moment,
	output logic [63:0]        sample_variance
);

	import plm_pkg::*;

	localparam int DEPTH = (LABEL_COUNT > 256) ? 256 : LABEL_COUNT;
	localparam int AW = $clog2(DEPTH);
	localparam logic [15:0] IMASK = 16'((1 << INTENSITY_BITS) - 1);
	localparam logic [15:0] CMASK = 16'((1 << COORD_BITS) - 1);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_READ  = 3'd1;
	localparam logic [2:0] S_LOAD  = 3'd2;
	localparam logic [2:0] S_ISSUE = 3'd3;
	localparam logic [2:0] S_WAIT  = 3'd4;
	localparam logic [2:0] S_WRITE = 3'd5;
	localparam logic [2:0] S_PUSH  = 3'd6;

	localparam logic [4:0] ST_DN    = 5'd0;
	localparam logic [4:0] ST_DN2   = 5'd1;
	localparam logic [4:0] ST_DDN   = 5'd2;
	localparam logic [4:0] ST_T1    = 5'd3;
	localparam logic [4:0] ST_POLY  = 5'd4;
	localparam logic [4:0] ST_T1DN2 = 5'd5;
	localparam logic [4:0] ST_P1    = 5'd6;
	localparam logic [4:0] ST_DN2M2 = 5'd7;
	localparam logic [4:0] ST_P2    = 5'd8;
	localparam logic [4:0] ST_DNM3  = 5'd9;
	localparam logic [4:0] ST_P3    = 5'd10;
	localparam logic [4:0] ST_T1DN  = 5'd11;
	localparam logic [4:0] ST_Q1    = 5'd12;
	localparam logic [4:0] ST_DNM2  = 5'd13;
	localparam logic [4:0] ST_Q2    = 5'd14;
	localparam logic [4:0] ST_VDIV  = 5'd15;
	localparam logic [4:0] ST_DD    = 5'd16;
	localparam logic [4:0] ST_PDIV  = 5'd17;

	function automatic sv_t sv_add(sv_t x, sv_t y);
		sv_t r;
		logic [64:0] s;
		s = {1'b0, x.mag} + {1'b0, y.mag};
		if (x.neg == y.neg) begin
			r.neg = x.neg;
			r.mag = s[64] ? MAX64 : s[63:0];
		end else if (x.mag >= y.mag) begin
			r.neg = x.neg;
			r.mag = x.mag - y.mag;
		end else begin
			r.neg = y.neg;
			r.mag = y.mag - x.mag;
		end
		if (r.mag == '0) begin
			r.neg = 1'b0;
		end
		return r;
	endfunction

	function automatic sv_t sv_make(logic neg, logic [63:0] mag);
		sv_t r;
		r.neg = neg && (mag != '0);
		r.mag = mag;
		return r;
	endfunction

	function automatic logic [63:0] sv_to_bits(sv_t v);
		logic [63:0] m;
		if (v.neg) begin
			m = (v.mag > 64'h8000_0000_0000_0000) ? 64'h8000_0000_0000_0000 : v.mag;
			return (~m) + 64'd1;
		end
		return (v.mag > 64'h7FFF_FFFF_FFFF_FFFF) ? 64'h7FFF_FFFF_FFFF_FFFF : v.mag;
	endfunction

	logic [2:0]       state_q;
	logic [4:0]       st_q;
	logic [DEPTH-1:0] seen_q;
	logic             first_q;
	logic             out_valid_q;

	logic [AW-1:0]    addr_q;
	logic [15:0]      iv_q;
	logic [15:0]      xv_q;
	logic [15:0]      yv_q;
	rec_t             old_q;
	logic             dneg_q;
	logic [31:0]      dmag_q;
	logic [32:0]      n_q;
	logic [31:0]      dn_q;
	logic [63:0]      dn2_q;
	logic [63:0]      t1_q;
	logic [63:0]      poly_q;
	logic [63:0]      tmp_q;
	logic [63:0]      p1_q;
	sv_t              acc4_q;
	sv_t              acc3_q;
	logic [63:0]      varn_q;
	rec_t             new_q;
	rec_t             out_q;

	logic             lab_ok;
	logic             ram_we;
	logic [$bits(rec_t)-1:0] ram_rdata;
	rec_t             rd_rec;
	rec_t             new_rec;
	ar_req_t          ar_req;
	logic [63:0]      ar_a;
	logic [63:0]      ar_b;
	logic             ar_done;
	logic [63:0]      ar_res;
	sv_t              m3sv;
	logic [32:0]      nm1;
	logic [32:0]      nm2;
	logic [31:0]      iq;
	logic [33:0]      mean_t;
	logic [48:0]      isum_t;
	logic [48:0]      xsum_t;
	logic [48:0]      ysum_t;
	logic [64:0]      m2_t;
	logic [64:0]      var_t;
	logic [16:0]      xp1;
	logic [16:0]      yp1;

	assign in_ready = (state_q == S_IDLE);
	assign lab_ok = (label_id != 8'd0) && ({24'b0, label_id} < 32'(LABEL_COUNT));
	assign ram_we = (state_q == S_WRITE);
	assign rd_rec = rec_t'(ram_rdata);
	assign m3sv = sv_make(old_q.m3[63], old_q.m3[63] ? (~old_q.m3) + 64'd1 : old_q.m3);
	assign nm1 = n_q - 33'd1;
	assign nm2 = n_q - 33'd2;
	assign iq = {iv_q, 16'b0};
	assign xp1 = {1'b0, xv_q} + 17'd1;
	assign yp1 = {1'b0, yv_q} + 17'd1;

	plm_ram #(
		.WIDTH($bits(rec_t)),
		.DEPTH(DEPTH)
	) u_ram (
		.clk(clk),
		.we(ram_we),
		.waddr(addr_q),
		.wdata(new_rec),
		.raddr(addr_q),
		.rdata(ram_rdata)
	);

	plm_arith u_arith (
		.clk(clk),
		.arst_n(arst_n),
		.req(ar_req),
		.a(ar_a),
		.b(ar_b),
		.done(ar_done),
		.result(ar_res)
	);

	always_comb begin
		ar_req.start = (state_q == S_ISSUE);
		ar_req.is_div = st_q inside {ST_DN, ST_VDIV, ST_PDIV};
		ar_req.sh16 = st_q inside {ST_DN2, ST_DDN, ST_T1DN2, ST_DN2M2, ST_DNM3, ST_T1DN,
			ST_DNM2, ST_DD};
		case (st_q)
			ST_DN: begin
				ar_a = {32'b0, dmag_q};
				ar_b = {31'b0, n_q};
			end
			ST_DN2: begin
				ar_a = {32'b0, dn_q};
				ar_b = {32'b0, dn_q};
			end
			ST_DDN: begin
				ar_a = {32'b0, dmag_q};
				ar_b = {32'b0, dn_q};
			end
			ST_T1: begin
				ar_a = tmp_q;
				ar_b = {32'b0, old_q.count};
			end
			ST_POLY: begin
				ar_a = {31'b0, nm1};
				ar_b = {31'b0, nm2};
			end
			ST_T1DN2: begin
				ar_a = t1_q;
				ar_b = dn2_q;
			end
			ST_P1: begin
				ar_a = tmp_q;
				ar_b = poly_q;
			end
			ST_DN2M2: begin
				ar_a = dn2_q;
				ar_b = old_q.m2;
			end
			ST_P2: begin
				ar_a = tmp_q;
				ar_b = 64'd6;
			end
			ST_DNM3: begin
				ar_a = {32'b0, dn_q};
				ar_b = m3sv.mag;
			end
			ST_P3: begin
				ar_a = tmp_q;
				ar_b = 64'd4;
			end
			ST_T1DN: begin
				ar_a = t1_q;
				ar_b = {32'b0, dn_q};
			end
			ST_Q1: begin
				ar_a = tmp_q;
				ar_b = {31'b0, nm2};
			end
			ST_DNM2: begin
				ar_a = {32'b0, dn_q};
				ar_b = old_q.m2;
			end
			ST_Q2: begin
				ar_a = tmp_q;
				ar_b = 64'd3;
			end
			ST_VDIV: begin
				ar_a = old_q.var_v;
				ar_b = {31'b0, nm1};
			end
			ST_DD: begin
				ar_a = {32'b0, dmag_q};
				ar_b = {32'b0, dmag_q};
			end
			ST_PDIV: begin
				ar_a = tmp_q;
				ar_b = {31'b0, n_q};
			end
			default: begin
				ar_a = '0;
				ar_b = '0;
			end
		endcase
	end

	always_comb begin
		mean_t = dneg_q ? ({2'b0, old_q.mean} - {2'b0, dn_q})
			: ({2'b0, old_q.mean} + {2'b0, dn_q});
		isum_t = {1'b0, old_q.isum} + {33'b0, iv_q};
		xsum_t = {1'b0, old_q.xsum} + {32'b0, xp1};
		ysum_t = {1'b0, old_q.ysum} + {32'b0, yp1};
		m2_t = {1'b0, old_q.m2} + {1'b0, t1_q};
		var_t = {1'b0, p1_q} + {1'b0, varn_q};
		if (first_q) begin
			new_rec.count = 32'd1;
			new_rec.mean = iq;
			new_rec.min_v = iv_q;
			new_rec.max_v = iv_q;
			new_rec.isum = {32'b0, iv_q};
			new_rec.xsum = {31'b0, xp1};
			new_rec.ysum = {31'b0, yp1};
			new_rec.m2 = '0;
			new_rec.m3 = '0;
			new_rec.m4 = '0;
			new_rec.var_v = '0;
		end else begin
			new_rec.count = n_q[32] ? MAX32 : n_q[31:0];
			new_rec.mean = (mean_t[33:32] != 2'b0) ? MAX32 : mean_t[31:0];
			new_rec.min_v = (iv_q < old_q.min_v) ? iv_q : old_q.min_v;
			new_rec.max_v = (iv_q > old_q.max_v) ? iv_q : old_q.max_v;
			new_rec.isum = isum_t[48] ? MAX48 : isum_t[47:0];
			new_rec.xsum = xsum_t[48] ? MAX48 : xsum_t[47:0];
			new_rec.ysum = ysum_t[48] ? MAX48 : ysum_t[47:0];
			new_rec.m2 = m2_t[64] ? MAX64 : m2_t[63:0];
			new_rec.m3 = sv_to_bits(acc3_q);
			new_rec.m4 = acc4_q.neg ? 64'd0 : acc4_q.mag;
			new_rec.var_v = var_t[64] ? MAX64 : var_t[63:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			st_q <= ST_DN;
			seen_q <= '0;
			first_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if ((state_q == S_PUSH) && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid && lab_ok) begin
						state_q <= S_READ;
					end
				end
				S_READ: begin
					state_q <= S_LOAD;
				end
				S_LOAD: begin
					first_q <= !seen_q[addr_q];
					st_q <= ST_DN;
					state_q <= seen_q[addr_q] ? S_ISSUE : S_WRITE;
				end
				S_ISSUE: begin
					state_q <= S_WAIT;
				end
				S_WAIT: begin
					if (ar_done) begin
						if (st_q == ST_PDIV) begin
							state_q <= S_WRITE;
						end else begin
							st_q <= st_q + 5'd1;
							state_q <= S_ISSUE;
						end
					end
				end
				S_WRITE: begin
					seen_q[addr_q] <= 1'b1;
					state_q <= S_PUSH;
				end
				S_PUSH: begin
					if (!out_valid_q || out_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				addr_q <= label_id[AW-1:0];
				iv_q <= pixel_intensity & IMASK;
				xv_q <= pixel_x & CMASK;
				yv_q <= pixel_y & CMASK;
			end
			S_LOAD: begin
				old_q <= rd_rec;
				dneg_q <= iq < rd_rec.mean;
				dmag_q <= (iq < rd_rec.mean) ? (rd_rec.mean - iq) : (iq - rd_rec.mean);
				n_q <= {1'b0, rd_rec.count} + 33'd1;
			end
			S_WAIT: begin
				if (ar_done) begin
					case (st_q)
						ST_DN: dn_q <= ar_res[31:0];
						ST_DN2: dn2_q <= ar_res;
						ST_T1: t1_q <= ar_res;
						ST_POLY: poly_q <= ar_res + 64'd1;
						ST_P1: acc4_q <= sv_add(sv_make(1'b0, old_q.m4), sv_make(1'b0, ar_res));
						ST_P2: acc4_q <= sv_add(acc4_q, sv_make(1'b0, ar_res));
						ST_P3: acc4_q <= sv_add(acc4_q, sv_make(!(dneg_q ^ m3sv.neg), ar_res));
						ST_Q1: acc3_q <= sv_add(m3sv, sv_make(dneg_q, ar_res));
						ST_Q2: acc3_q <= sv_add(acc3_q, sv_make(!dneg_q, ar_res));
						ST_VDIV: p1_q <= old_q.var_v - ar_res;
						ST_PDIV: varn_q <= ar_res;
						default: tmp_q <= ar_res;
					endcase
				end
			end
			S_WRITE: begin
				new_q <= new_rec;
			end
			S_PUSH: begin
				if (!out_valid_q || out_ready) begin
					out_q <= new_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign pixel_count = out_q.count;
	assign mean_value = out_q.mean;
	assign min_value = out_q.min_v;
	assign max_value = out_q.max_v;
	assign intensity_sum = out_q.isum;
	assign x_sum = out_q.xsum;
	assign y_sum = out_q.ysum;
	assign second_moment = out_q.m2;
	assign third_moment = out_q.m3;
	assign fourth_moment = out_q.m4;
	assign sample_variance = out_q.var_v;

`ifndef SYNTH
	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		ar_done |-> (state_q == S_WAIT))
		else $error("arithmetic result outside wait state");
	a_no_bg_write: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (addr_q != '0))
		else $error("table write to background label");
	a_seen_after_write: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |=> seen_q[$past(addr_q)])
		else $error("label not marked seen after write");
	a_push_after_write: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |=> (state_q == S_PUSH))
		else $error("write not followed by result push");
`endif

endmodule
